FILE: rtl/hdt_pkg.sv
// Shared types and constants for the heading turn controller.
`default_nettype none

package hdt_pkg;

   localparam int unsigned ANGLE_W = 24;
   localparam int unsigned ERROR_W = 25;
   localparam int unsigned DELTA_W = 26;
   localparam int unsigned DRIVE_W = 12;
   localparam int unsigned COUNT_W = 8;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_PROP_GAIN    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DERIV_GAIN   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIVE_LIMIT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STILL_BAND   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WARMUP_TICKS = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE_LIMIT = 3'd5;

   localparam logic [15:0] PROP_GAIN_RESET    = 16'd128;
   localparam logic [15:0] DERIV_GAIN_RESET   = 16'd768;
   localparam logic [10:0] DRIVE_LIMIT_RESET  = 11'd1200;
   localparam logic [9:0]  STILL_BAND_RESET   = 10'd5;
   localparam logic [7:0]  WARMUP_TICKS_RESET = 8'd10;
   localparam logic [7:0]  SETTLE_LIMIT_RESET = 8'd10;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Per-transaction control word from the settle tracker to the drive path.
   typedef struct packed {
      logic                      hold;        // repeat the held drive
      logic                      done;        // turn finished after this tick
      logic signed [ERROR_W-1:0] error;       // target minus heading
      logic signed [DELTA_W-1:0] error_delta; // error minus previous error
   } step_type;

endpackage : hdt_pkg

`default_nettype wire

FILE: rtl/hdt_settle_track.sv
// Turn state tracking: start handling, error terms and settle detection.
`default_nettype none

module hdt_settle_track (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              step_en,
   input  wire logic                              start_req,
   input  wire logic signed [hdt_pkg::ANGLE_W-1:0] target_angle,
   input  wire logic signed [hdt_pkg::ANGLE_W-1:0] heading,
   input  wire logic [9:0]                        still_band,
   input  wire logic [7:0]                        warmup_ticks,
   input  wire logic [7:0]                        settle_limit,
   output hdt_pkg::step_type                      step
);

   logic signed [hdt_pkg::ERROR_W-1:0] last_error_ff, last_error_in;
   logic signed [hdt_pkg::ANGLE_W-1:0] last_heading_ff, last_heading_in;
   logic [hdt_pkg::COUNT_W-1:0]        still_count_ff, still_count_in;
   logic [hdt_pkg::COUNT_W-1:0]        elapsed_ff, elapsed_in;
   logic                               finished_ff, finished_in;

   logic signed [hdt_pkg::ERROR_W-1:0] base_error;
   logic signed [hdt_pkg::ANGLE_W-1:0] base_heading;
   logic [hdt_pkg::COUNT_W-1:0]        base_still;
   logic [hdt_pkg::COUNT_W-1:0]        base_elapsed;
   logic                               base_finished;
   logic signed [hdt_pkg::ERROR_W-1:0] error;
   logic signed [hdt_pkg::ERROR_W-1:0] head_step;
   logic [hdt_pkg::ERROR_W-1:0]        head_mag;
   logic                               is_still;
   logic [hdt_pkg::COUNT_W-1:0]        still_next;

   always_comb begin
      // A start wipes the turn state before the tick runs.
      base_error    = start_req ? '0 : last_error_ff;
      base_heading  = start_req ? heading : last_heading_ff;
      base_still    = start_req ? '0 : still_count_ff;
      base_elapsed  = start_req ? '0 : elapsed_ff;
      base_finished = start_req ? 1'b0 : finished_ff;

      error = {target_angle[hdt_pkg::ANGLE_W-1], target_angle}
            - {heading[hdt_pkg::ANGLE_W-1], heading};

      head_step = {heading[hdt_pkg::ANGLE_W-1], heading}
                - {base_heading[hdt_pkg::ANGLE_W-1], base_heading};
      head_mag  = head_step[hdt_pkg::ERROR_W-1] ? hdt_pkg::ERROR_W'(-head_step)
                                                : hdt_pkg::ERROR_W'(head_step);
      is_still  = (head_mag < {15'd0, still_band}) && (base_elapsed > warmup_ticks);

      if (!is_still) begin
         still_next = '0;
      end else if (base_still != hdt_pkg::COUNT_MAX) begin
         still_next = base_still + 1'b1;
      end else begin
         still_next = base_still;
      end

      step.hold        = base_finished;
      step.done        = base_finished || (still_next > settle_limit);
      step.error       = error;
      step.error_delta = {error[hdt_pkg::ERROR_W-1], error}
                       - {base_error[hdt_pkg::ERROR_W-1], base_error};

      // Finished turns, and ticks without step_en, leave the state untouched.
      last_error_in   = last_error_ff;
      last_heading_in = last_heading_ff;
      still_count_in  = still_count_ff;
      elapsed_in      = elapsed_ff;
      finished_in     = finished_ff;
      if (step_en && !base_finished) begin
         last_error_in   = error;
         last_heading_in = heading;
         still_count_in  = still_next;
         elapsed_in      = (base_elapsed != hdt_pkg::COUNT_MAX) ? base_elapsed + 1'b1
                                                                 : base_elapsed;
         finished_in     = still_next > settle_limit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff   <= '0;
         last_heading_ff <= '0;
         still_count_ff  <= '0;
         elapsed_ff      <= '0;
         finished_ff     <= 1'b1;
      end else begin
         last_error_ff   <= last_error_in;
         last_heading_ff <= last_heading_in;
         still_count_ff  <= still_count_in;
         elapsed_ff      <= elapsed_in;
         finished_ff     <= finished_in;
      end
   end

endmodule : hdt_settle_track

`default_nettype wire

FILE: rtl/pd_heading_turn_controller_unit.sv
// PD heading turn controller: top level with CSRs and the three-stage drive pipeline.
// An accepted request passes through the input, product and result stages in order to rsp_valid.
// Throughput: one transaction per cycle unless rsp_stall holds the pipeline; the turn state
// closes its loop within the input stage, and the two gain multipliers sit alone in the middle stage.
// Reset: CSRs return to their defaults, the pipeline empties, and the controller is
// finished with a zero held drive, so it repeats zero drive with done set until a start.
`default_nettype none

module pd_heading_turn_controller_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_start_req,
   input  wire logic signed [hdt_pkg::ANGLE_W-1:0]   req_target_angle,
   input  wire logic signed [hdt_pkg::ANGLE_W-1:0]   req_heading,
   // response channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [hdt_pkg::DRIVE_W-1:0]        rsp_left_drive,
   output logic signed [hdt_pkg::DRIVE_W-1:0]        rsp_right_drive,
   output logic                                      rsp_done_res,
   // CSR write channel
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [hdt_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [hdt_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   // ------------------------------------------------------------------
   // CSRs: always ready; writes to unused indexes are dropped.
   // ------------------------------------------------------------------
   logic [15:0] prop_gain_ff,    prop_gain_in;
   logic [15:0] deriv_gain_ff,   deriv_gain_in;
   logic [10:0] drive_limit_ff,  drive_limit_in;
   logic [9:0]  still_band_ff,   still_band_in;
   logic [7:0]  warmup_ticks_ff, warmup_ticks_in;
   logic [7:0]  settle_limit_ff, settle_limit_in;

   assign csr_ready = 1'b1;

   always_comb begin
      prop_gain_in    = prop_gain_ff;
      deriv_gain_in   = deriv_gain_ff;
      drive_limit_in  = drive_limit_ff;
      still_band_in   = still_band_ff;
      warmup_ticks_in = warmup_ticks_ff;
      settle_limit_in = settle_limit_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            hdt_pkg::CSR_PROP_GAIN:    prop_gain_in    = csr_wdata;
            hdt_pkg::CSR_DERIV_GAIN:   deriv_gain_in   = csr_wdata;
            hdt_pkg::CSR_DRIVE_LIMIT:  drive_limit_in  = csr_wdata[10:0];
            hdt_pkg::CSR_STILL_BAND:   still_band_in   = csr_wdata[9:0];
            hdt_pkg::CSR_WARMUP_TICKS: warmup_ticks_in = csr_wdata[7:0];
            hdt_pkg::CSR_SETTLE_LIMIT: settle_limit_in = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff    <= hdt_pkg::PROP_GAIN_RESET;
         deriv_gain_ff   <= hdt_pkg::DERIV_GAIN_RESET;
         drive_limit_ff  <= hdt_pkg::DRIVE_LIMIT_RESET;
         still_band_ff   <= hdt_pkg::STILL_BAND_RESET;
         warmup_ticks_ff <= hdt_pkg::WARMUP_TICKS_RESET;
         settle_limit_ff <= hdt_pkg::SETTLE_LIMIT_RESET;
      end else begin
         prop_gain_ff    <= prop_gain_in;
         deriv_gain_ff   <= deriv_gain_in;
         drive_limit_ff  <= drive_limit_in;
         still_band_ff   <= still_band_in;
         warmup_ticks_ff <= warmup_ticks_in;
         settle_limit_ff <= settle_limit_in;
      end
   end

   // ------------------------------------------------------------------
   // Pipeline flow control: a stage loads when it is empty or its
   // contents move on in the same cycle.
   // ------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic s1_load, s2_load, s3_load;
   logic req_accept;

   assign s3_load    = !s3_valid_ff || !rsp_stall;
   assign s2_load    = !s2_valid_ff || s3_load;
   assign s1_load    = !s1_valid_ff || s2_load;
   assign req_stall  = !s1_load;
   assign req_accept = req_valid && s1_load;

   assign s1_valid_in = s1_load ? req_valid   : s1_valid_ff;
   assign s2_valid_in = s2_load ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_load ? s2_valid_ff : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: turn state update and error terms, taken on accept.
   // ------------------------------------------------------------------
   hdt_pkg::step_type step;
   hdt_pkg::step_type s1_step_ff, s1_step_in;

   hdt_settle_track u_settle (
      .clock        (clock),
      .reset        (reset),
      .step_en      (req_accept),
      .start_req    (req_start_req),
      .target_angle (req_target_angle),
      .heading      (req_heading),
      .still_band   (still_band_ff),
      .warmup_ticks (warmup_ticks_ff),
      .settle_limit (settle_limit_ff),
      .step         (step)
   );

   assign s1_step_in = req_accept ? step : s1_step_ff;

   always_ff @(posedge clock) begin
      s1_step_ff <= s1_step_in;
   end

   // ------------------------------------------------------------------
   // Stage 2: gain products. Gains are unsigned Q8.8, so zero-extend them.
   // ------------------------------------------------------------------
   localparam int unsigned PPROD_W = hdt_pkg::ERROR_W + 17;
   localparam int unsigned DPROD_W = hdt_pkg::DELTA_W + 17;
   localparam int unsigned SUM_W   = DPROD_W + 1;
   localparam int unsigned SHR_W   = SUM_W - 8;

   logic signed [PPROD_W-1:0] p_prod_ff, p_prod_in;
   logic signed [DPROD_W-1:0] d_prod_ff, d_prod_in;
   logic                      s2_hold_ff, s2_hold_in;
   logic                      s2_done_ff, s2_done_in;

   always_comb begin
      p_prod_in  = p_prod_ff;
      d_prod_in  = d_prod_ff;
      s2_hold_in = s2_hold_ff;
      s2_done_in = s2_done_ff;
      if (s2_load && s1_valid_ff) begin
         p_prod_in  = $signed({1'b0, prop_gain_ff}) * s1_step_ff.error;
         d_prod_in  = $signed({1'b0, deriv_gain_ff}) * s1_step_ff.error_delta;
         s2_hold_in = s1_step_ff.hold;
         s2_done_in = s1_step_ff.done;
      end
   end

   always_ff @(posedge clock) begin
      p_prod_ff  <= p_prod_in;
      d_prod_ff  <= d_prod_in;
      s2_hold_ff <= s2_hold_in;
      s2_done_ff <= s2_done_in;
   end

   // ------------------------------------------------------------------
   // Stage 3: sum, floor shift by 8, clamp, and the held-drive register.
   // A finished turn repeats the last active drive, which in order has
   // already passed this stage.
   // ------------------------------------------------------------------
   logic signed [SUM_W-1:0]           pd_sum;
   logic signed [SHR_W-1:0]           pd_shr;
   logic signed [SHR_W-1:0]           pd_lim;
   logic signed [SHR_W-1:0]           pd_clamp;
   logic signed [hdt_pkg::DRIVE_W-1:0] drive_ff, drive_in;
   logic signed [hdt_pkg::DRIVE_W-1:0] held_drive_ff, held_drive_in;
   logic                              done_ff, done_in;

   always_comb begin
      pd_sum = {{(SUM_W-PPROD_W){p_prod_ff[PPROD_W-1]}}, p_prod_ff}
             + {d_prod_ff[DPROD_W-1], d_prod_ff};
      pd_shr = pd_sum[SUM_W-1:8];
      pd_lim = {{(SHR_W-11){1'b0}}, drive_limit_ff};
      priority if (pd_shr > pd_lim) begin
         pd_clamp = pd_lim;
      end else if (pd_shr < -pd_lim) begin
         pd_clamp = -pd_lim;
      end else begin
         pd_clamp = pd_shr;
      end

      drive_in      = drive_ff;
      done_in       = done_ff;
      held_drive_in = held_drive_ff;
      if (s3_load && s2_valid_ff) begin
         done_in = s2_done_ff;
         if (s2_hold_ff) begin
            drive_in = held_drive_ff;
         end else begin
            drive_in      = pd_clamp[hdt_pkg::DRIVE_W-1:0];
            held_drive_in = pd_clamp[hdt_pkg::DRIVE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_drive_ff <= '0;
      end else begin
         held_drive_ff <= held_drive_in;
      end
      drive_ff <= drive_in;
      done_ff  <= done_in;
   end

   assign rsp_valid       = s3_valid_ff;
   assign rsp_left_drive  = drive_ff;
   assign rsp_right_drive = -drive_ff;
   assign rsp_done_res    = done_ff;

endmodule : pd_heading_turn_controller_unit

`default_nettype wire
